// File: hw/rtl/tlsrf_pkg.sv
// Shared constants and types for the TLS record framer.
package tlsrf_pkg;

    localparam logic [7:0] TYPE_CCS       = 8'h14;
    localparam logic [7:0] TYPE_LAST      = 8'h17;
    localparam logic [7:0] TYPE_HANDSHAKE = 8'h16;
    localparam logic [7:0] MAJOR_VERSION  = 8'h03;
    localparam logic [7:0] MINOR_MAX      = 8'h03;
    localparam logic [7:0] HELLO_CLIENT   = 8'h01;
    localparam logic [7:0] HELLO_SERVER   = 8'h02;

    localparam int HDR_BYTES  = 5;
    localparam int HS_BYTES   = 4;
    localparam int STORE_DEPTH = HDR_BYTES + HS_BYTES;

    localparam logic [15:0] REC_LEN_LIMIT_RESET  = 16'h4800;
    localparam logic [15:0] MAX_RECORDS_RESET    = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX            = 16'hFFFF;

    typedef enum logic [1:0] {
        CFG_FROM_CLIENT    = 2'd0,
        CFG_REC_LEN_LIMIT  = 2'd1,
        CFG_MAX_RECORDS    = 2'd2
    } cfg_index_t;

    // One result word as it is held in the output register.
    typedef struct packed {
        logic        limit_hit;
        logic        hello_missing;
        logic [7:0]  hs_type;
        logic [15:0] length_field;
        logic [15:0] rec_version;
        logic [7:0]  rec_type;
        logic        not_record;
        logic        item_done;
        logic [7:0]  data_out;
        logic        data_valid;
        logic        handshake_seen;
        logic        header_seen;
    } result_t;

endpackage

// File: hw/rtl/tls_record_framer_unit.sv
// TLS record-layer framer for one direction of a TCP byte stream.

// The framer takes one in-order TCP payload byte per input word and returns
// exactly one result word for it. It gathers the five-byte record header,
// checks it on the following byte (content type 0x14 to 0x17, version 3.0
// to 3.3, nonzero length below the configured record length limit) and then
// frames the body.
// Plaintext handshake records are split further into handshake messages by
// their four-byte headers; all other records are framed whole. A header that
// fails the check drops the rest of the TCP segment. After max_records
// records or messages have completed, every further byte is ignored and
// limit_hit stays set until reset. Throughput is one byte per clock cycle
// while the sink keeps taking results: all state (header bytes, position
// counters, record counter, status bits) is updated by a single short pass
// of logic when a word is accepted, and its result goes into the output
// register. The output register lets a new byte be accepted in the same
// cycle that the previous result is taken. Configuration is written through
// cfg_we, cfg_index and cfg_data and must only change while the framer is idle.
module tls_record_framer_unit (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
    input  logic        s_axis_tlast,   // segment_last

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data_out, [15:8] rec_type, [31:16] rec_version,
    // [47:32] length_field, [55:48] hs_type, [56] hello_missing,
    // [57] limit_hit, [63:58] zero
    output logic [63:0] m_axis_tdata,
    // [0] header_seen, [1] handshake_seen, [2] data_valid, [3] not_record
    output logic [3:0]  m_axis_tuser,
    output logic        m_axis_tlast    // item_done
);
    import tlsrf_pkg::*;

    // Configuration registers.
    logic        from_client_reg;
    logic [15:0] rec_len_limit_reg;
    logic [15:0] max_records_reg;

    // Framer state.
    logic [7:0]  hdr_reg  [STORE_DEPTH];
    logic [7:0]  hdr_next [STORE_DEPTH];
    logic [16:0] rec_pos_reg, rec_pos_next;
    logic [15:0] rec_len_reg, rec_len_next;
    logic [16:0] hs_pos_reg, hs_pos_next;
    logic [15:0] hs_len_reg, hs_len_next;
    logic [7:0]  prev_type_reg, prev_type_next;
    logic [15:0] rec_count_reg, rec_count_next;
    logic        hello_reg, hello_next;
    logic        skip_reg, skip_next;
    logic        stop_reg, stop_next;

    // Output register.
    logic        out_valid_reg;
    result_t     result_reg, result_next;

    logic        accept;
    logic [7:0]  in_byte;
    logic        in_last;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_byte       = s_axis_tdata;
    assign in_last       = s_axis_tlast;

    // Header check on the collected record header.
    logic [15:0] hdr_len;
    logic        hdr_ok;
    logic        plain_hs;

    assign hdr_len  = {hdr_reg[3], hdr_reg[4]};
    assign hdr_ok   = (hdr_reg[0] >= TYPE_CCS) && (hdr_reg[0] <= TYPE_LAST)
                   && (hdr_reg[1] == MAJOR_VERSION) && (hdr_reg[2] <= MINOR_MAX)
                   && (hdr_len != 16'd0) && (hdr_len < rec_len_limit_reg);
    // A handshake record is plaintext unless a ChangeCipherSpec came before it.
    assign plain_hs = (hdr_reg[0] == TYPE_HANDSHAKE) && (prev_type_reg != TYPE_CCS);

    always_comb
    begin
        logic        go;
        logic        end_msg;
        logic        count_it;
        logic [16:0] rec_pos_inc;
        logic [16:0] hs_pos_inc;
        logic [15:0] count_inc;
        logic [7:0]  want;
        logic        hd_seen;
        logic        hs_seen;
        logic        dv;
        logic        done;
        logic        nr;

        hdr_next       = hdr_reg;
        rec_pos_next   = rec_pos_reg;
        rec_len_next   = rec_len_reg;
        hs_pos_next    = hs_pos_reg;
        hs_len_next    = hs_len_reg;
        prev_type_next = prev_type_reg;
        rec_count_next = rec_count_reg;
        hello_next     = hello_reg;
        skip_next      = skip_reg;
        stop_next      = stop_reg;

        go          = 1'b0;
        end_msg     = 1'b0;
        count_it    = 1'b0;
        hd_seen     = 1'b0;
        hs_seen     = 1'b0;
        dv          = 1'b0;
        done        = 1'b0;
        nr          = 1'b0;
        rec_pos_inc = rec_pos_reg + 17'd1;
        hs_pos_inc  = hs_pos_reg + 17'd1;
        want        = from_client_reg ? HELLO_CLIENT : HELLO_SERVER;

        if (stop_reg || (rec_count_reg >= max_records_reg))
        begin
            stop_next = 1'b1;
        end
        else if (skip_reg)
        begin
            if (in_last)
            begin
                skip_next = 1'b0;
            end
        end
        else if (rec_pos_reg < 17'(HDR_BYTES))
        begin
            // Still gathering the record header.
            hdr_next[rec_pos_reg[3:0]] = in_byte;
            rec_pos_next = rec_pos_inc;
        end
        else
        begin
            go = 1'b1;
            if (rec_pos_reg == 17'(HDR_BYTES))
            begin
                if (!hdr_ok)
                begin
                    rec_pos_next = 17'd0;
                    nr           = 1'b1;
                    go           = 1'b0;
                    if (!in_last)
                    begin
                        skip_next = 1'b1;
                    end
                end
                else
                begin
                    // The first record must be a hello of the expected kind.
                    if ((rec_count_reg == 16'd0)
                        && ((hdr_reg[0] != TYPE_HANDSHAKE) || (in_byte != want)))
                    begin
                        hello_next = 1'b1;
                    end
                    rec_len_next = hdr_len;
                    hd_seen      = !plain_hs;
                end
            end

            if (go)
            begin
                if (rec_pos_inc >= ({1'b0, rec_len_next} + 17'(HDR_BYTES)))
                begin
                    rec_pos_next = 17'd0;
                end
                else
                begin
                    rec_pos_next = rec_pos_inc;
                end

                if (plain_hs)
                begin
                    if (hs_pos_inc <= 17'(HS_BYTES))
                    begin
                        // Handshake message header bytes go to the upper store.
                        hdr_next[4'(hs_pos_inc) + 4'(HDR_BYTES - 1)] = in_byte;
                        if (hs_pos_inc == 17'(HS_BYTES))
                        begin
                            hs_seen     = 1'b1;
                            hs_len_next = {hdr_reg[7], in_byte};
                            end_msg     = (hs_len_next == 16'd0);
                        end
                    end
                    else
                    begin
                        dv      = 1'b1;
                        end_msg = (hs_pos_inc >= ({1'b0, hs_len_reg} + 17'(HS_BYTES)));
                    end

                    if (end_msg)
                    begin
                        hs_pos_next    = 17'd0;
                        prev_type_next = TYPE_HANDSHAKE;
                        done           = 1'b1;
                        count_it       = 1'b1;
                    end
                    else
                    begin
                        hs_pos_next = hs_pos_inc;
                    end
                end
                else
                begin
                    dv = 1'b1;
                    if (rec_pos_inc >= ({1'b0, rec_len_next} + 17'(HDR_BYTES)))
                    begin
                        prev_type_next = hdr_reg[0];
                        done           = 1'b1;
                        count_it       = 1'b1;
                    end
                end
            end
        end

        // Saturating record counter; reaching the limit stops the framer.
        count_inc = (rec_count_reg != COUNT_MAX) ? (rec_count_reg + 16'd1) : rec_count_reg;
        if (count_it)
        begin
            rec_count_next = count_inc;
            if (count_inc >= max_records_reg)
            begin
                stop_next = 1'b1;
            end
        end

        result_next.header_seen    = hd_seen;
        result_next.handshake_seen = hs_seen;
        result_next.data_valid     = dv;
        result_next.data_out       = dv ? in_byte : 8'd0;
        result_next.item_done      = done;
        result_next.not_record     = nr;
        result_next.rec_type       = hdr_next[0];
        result_next.rec_version    = {hdr_next[1], hdr_next[2]};
        result_next.length_field   = hs_seen ? hs_len_next : rec_len_next;
        result_next.hs_type        = hdr_next[5];
        result_next.hello_missing  = hello_next;
        result_next.limit_hit      = stop_next;
    end

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            from_client_reg   <= 1'b1;
            rec_len_limit_reg <= REC_LEN_LIMIT_RESET;
            max_records_reg   <= MAX_RECORDS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FROM_CLIENT:   from_client_reg   <= cfg_data[0];
                CFG_REC_LEN_LIMIT: rec_len_limit_reg <= cfg_data;
                CFG_MAX_RECORDS:   max_records_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Framer state advances once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                hdr_reg[i] <= 8'd0;
            end
            rec_pos_reg   <= 17'd0;
            rec_len_reg   <= 16'd0;
            hs_pos_reg    <= 17'd0;
            hs_len_reg    <= 16'd0;
            prev_type_reg <= 8'd0;
            rec_count_reg <= 16'd0;
            hello_reg     <= 1'b0;
            skip_reg      <= 1'b0;
            stop_reg      <= 1'b0;
        end
        else if (accept)
        begin
            hdr_reg       <= hdr_next;
            rec_pos_reg   <= rec_pos_next;
            rec_len_reg   <= rec_len_next;
            hs_pos_reg    <= hs_pos_next;
            hs_len_reg    <= hs_len_next;
            prev_type_reg <= prev_type_next;
            rec_count_reg <= rec_count_next;
            hello_reg     <= hello_next;
            skip_reg      <= skip_next;
            stop_reg      <= stop_next;
        end
    end

    // Output register: holds one result word until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0,
                            result_reg.limit_hit,
                            result_reg.hello_missing,
                            result_reg.hs_type,
                            result_reg.length_field,
                            result_reg.rec_version,
                            result_reg.rec_type,
                            result_reg.data_out};
    assign m_axis_tuser  = {result_reg.not_record,
                            result_reg.data_valid,
                            result_reg.handshake_seen,
                            result_reg.header_seen};
    assign m_axis_tlast  = result_reg.item_done;

endmodule

// File: tb/tb_tls_record_framer_unit.sv
// Self-checking stream testbench for the TLS record framer unit.
`timescale 1ns / 1ps

module tb_tls_record_framer_unit;

    import tlsrf_pkg::*;

    // Content type between ChangeCipherSpec and Handshake.
    localparam logic [7:0] TYPE_ALERT       = 8'h15;
    // The index field is two bits wide, so one code has no register behind it.
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;
    // Generous bound on the length of the whole run.
    localparam int unsigned CYCLE_LIMIT     = 400_000;

    // Keeps its own copy of the framer state and configuration. It works out
    // the result word that each accepted byte must produce and checks the
    // returned words in order against those expectations.
    class framer_scoreboard;
        logic        from_client;
        logic [15:0] rec_len_limit;
        logic [15:0] max_records;
        logic [7:0]  hdr [STORE_DEPTH];
        int unsigned rec_pos;
        int unsigned rec_len;
        int unsigned hs_pos;
        int unsigned hs_len;
        logic [7:0]  prev_type;
        logic [15:0] rec_count;
        logic        hello_missing;
        logic        skip_segment;
        logic        stopped;
        result_t     expected_q [$];
        int unsigned n_bytes;
        int unsigned n_results;
        int unsigned n_headers;
        int unsigned n_hs_headers;
        int unsigned n_rejected;
        int unsigned n_closed;
        int unsigned mismatches;

        function new();
            from_client    = 1'b1;
            rec_len_limit  = REC_LEN_LIMIT_RESET;
            max_records    = MAX_RECORDS_RESET;
            foreach (hdr[i])
                hdr[i] = '0;
            rec_pos       = 0;
            rec_len       = 0;
            hs_pos        = 0;
            hs_len        = 0;
            prev_type     = '0;
            rec_count     = '0;
            hello_missing = 1'b0;
            skip_segment  = 1'b0;
            stopped       = 1'b0;
            n_bytes       = 0;
            n_results     = 0;
            n_headers     = 0;
            n_hs_headers  = 0;
            n_rejected    = 0;
            n_closed      = 0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_FROM_CLIENT:   from_client = val[0];
                CFG_REC_LEN_LIMIT: rec_len_limit = val;
                CFG_MAX_RECORDS:   max_records = val;
                default:           ;
            endcase
        endfunction

        // A handshake record is plaintext unless ChangeCipherSpec came first.
        function bit plain_handshake();
            return hdr[0] == TYPE_HANDSHAKE && prev_type != TYPE_CCS;
        endfunction

        function void close_item();
            if (rec_count < COUNT_MAX)
                rec_count++;
            if (rec_count >= max_records)
                stopped = 1'b1;
            n_closed++;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            result_t     r;
            bit          go;
            bit          end_msg;
            bit          valid;
            logic [15:0] hdr_len;
            r = '0;
            n_bytes++;
            if (stopped || rec_count >= max_records)
            begin
                stopped = 1'b1;
            end
            else if (skip_segment)
            begin
                if (last)
                    skip_segment = 1'b0;
            end
            else if (rec_pos < HDR_BYTES)
            begin
                hdr[rec_pos] = b;
                rec_pos++;
            end
            else
            begin
                go = 1'b1;
                if (rec_pos == HDR_BYTES)
                begin
                    // The header is judged on the first byte after it.
                    hdr_len = {hdr[3], hdr[4]};
                    valid = hdr[0] >= TYPE_CCS && hdr[0] <= TYPE_LAST &&
                            hdr[1] == MAJOR_VERSION && hdr[2] <= MINOR_MAX &&
                            hdr_len != 16'd0 && hdr_len < rec_len_limit;
                    if (!valid)
                    begin
                        rec_pos = 0;
                        r.not_record = 1'b1;
                        if (!last)
                            skip_segment = 1'b1;
                        go = 1'b0;
                    end
                    else
                    begin
                        if (rec_count == 16'd0 && (hdr[0] != TYPE_HANDSHAKE ||
                            b != (from_client ? HELLO_CLIENT : HELLO_SERVER)))
                            hello_missing = 1'b1;
                        rec_len = hdr_len;
                        if (!plain_handshake())
                            r.header_seen = 1'b1;
                    end
                end
                if (go)
                begin
                    if (plain_handshake())
                    begin
                        end_msg = 1'b0;
                        rec_pos++;
                        if (rec_pos >= rec_len + HDR_BYTES)
                            rec_pos = 0;
                        hs_pos++;
                        if (hs_pos <= HS_BYTES)
                        begin
                            hdr[HDR_BYTES - 1 + hs_pos] = b;
                            if (hs_pos == HS_BYTES)
                            begin
                                r.handshake_seen = 1'b1;
                                hs_len = {hdr[7], hdr[8]};
                                if (hs_len == 0)
                                    end_msg = 1'b1;
                            end
                        end
                        else
                        begin
                            r.data_valid = 1'b1;
                            if (hs_pos >= hs_len + HS_BYTES)
                                end_msg = 1'b1;
                        end
                        if (end_msg)
                        begin
                            hs_pos = 0;
                            prev_type = TYPE_HANDSHAKE;
                            r.item_done = 1'b1;
                            close_item();
                        end
                    end
                    else
                    begin
                        r.data_valid = 1'b1;
                        rec_pos++;
                        if (rec_pos >= rec_len + HDR_BYTES)
                        begin
                            rec_pos = 0;
                            prev_type = hdr[0];
                            r.item_done = 1'b1;
                            close_item();
                        end
                    end
                end
            end
            r.data_out      = r.data_valid ? b : 8'h00;
            r.rec_type      = hdr[0];
            r.rec_version   = {hdr[1], hdr[2]};
            r.length_field  = r.handshake_seen ? 16'(hs_len) : 16'(rec_len);
            r.hs_type       = hdr[5];
            r.hello_missing = hello_missing;
            r.limit_hit     = stopped;
            n_headers      += r.header_seen;
            n_hs_headers   += r.handshake_seen;
            n_rejected     += r.not_record;
            expected_q.push_back(r);
        endfunction

        function string describe(result_t r);
            return $sformatf({"hdr=%0b hs=%0b dv=%0b data=%h done=%0b bad=%0b type=%h ",
                              "ver=%h len=%h hs_type=%h hello=%0b limit=%0b"},
                             r.header_seen, r.handshake_seen, r.data_valid, r.data_out,
                             r.item_done, r.not_record, r.rec_type, r.rec_version,
                             r.length_field, r.hs_type, r.hello_missing, r.limit_hit);
        endfunction

        function void report(string what, result_t want, result_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%s", what);
                $display("  expected %s", describe(want));
                $display("  actual   %s", describe(got));
            end
        endfunction

        function void check_result(result_t got, logic [5:0] pad);
            result_t want;
            n_results++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("word %0d arrived with no byte waiting", n_results),
                       '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want || pad !== 6'd0)
                report($sformatf("mismatch on word %0d (pad bits %b)", n_results, pad),
                       want, got);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] payload_byte
    logic        s_axis_tlast;   // segment_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] data_out, [15:8] rec_type, [31:16] rec_version,
    // [47:32] length_field, [55:48] hs_type, [56] hello_missing,
    // [57] limit_hit, [63:58] zero
    logic [63:0] m_axis_tdata;
    // [0] header_seen, [1] handshake_seen, [2] data_valid, [3] not_record
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;   // item_done

    framer_scoreboard sb;
    result_t          seen_word;
    int unsigned      cycle_count = 0;
    int unsigned      src_idle_pct = 0;
    int unsigned      sink_stall_pct = 0;

    // Bytes waiting to be offered, with their end-of-segment marks, and the
    // stream of handshake messages that plaintext handshake records carry.
    logic [7:0]       pend_byte [$];
    logic             pend_last [$];
    logic [7:0]       hs_feed [$];

    tls_record_framer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // The receiver stalls at random with the percentage of the current phase.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Unpack the result word from the output ports.
    always_comb
    begin
        seen_word                = '0;
        seen_word.header_seen    = m_axis_tuser[0];
        seen_word.handshake_seen = m_axis_tuser[1];
        seen_word.data_valid     = m_axis_tuser[2];
        seen_word.not_record     = m_axis_tuser[3];
        seen_word.item_done      = m_axis_tlast;
        seen_word.data_out       = m_axis_tdata[7:0];
        seen_word.rec_type       = m_axis_tdata[15:8];
        seen_word.rec_version    = m_axis_tdata[31:16];
        seen_word.length_field   = m_axis_tdata[47:32];
        seen_word.hs_type        = m_axis_tdata[55:48];
        seen_word.hello_missing  = m_axis_tdata[56];
        seen_word.limit_hit      = m_axis_tdata[57];
    end

    // Both handshakes are sampled at the clock edge, before any of this edge's
    // nonblocking updates, so the order of processes within the step is moot.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(seen_word, m_axis_tdata[63:58]);
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d words still expected",
                 cycle_count, sb.expected_q.size());
        $display("[tls_record_framer_unit] ERROR");
        $finish;
    end

    function automatic void push_byte(logic [7:0] b, logic last);
        pend_byte.push_back(b);
        pend_last.push_back(last);
    endfunction

    // Header bytes now and then carry an end-of-segment mark, which the
    // framer must ignore while it collects a header.
    function automatic void queue_header(logic [7:0] typ, logic [7:0] maj,
                                         logic [7:0] mnr, logic [15:0] len);
        push_byte(typ, $urandom_range(99) < 3);
        push_byte(maj, $urandom_range(99) < 3);
        push_byte(mnr, $urandom_range(99) < 3);
        push_byte(len[15:8], $urandom_range(99) < 3);
        push_byte(len[7:0], $urandom_range(99) < 3);
    endfunction

    // Handshake messages: type, 24-bit length of which the top byte is
    // sometimes junk, then the body. Some messages have an empty body.
    function automatic logic [7:0] next_hs_byte();
        int unsigned n;
        if (hs_feed.size() == 0)
        begin
            n = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 14);
            if ($urandom_range(99) < 30)
                hs_feed.push_back($urandom_range(1) ? HELLO_CLIENT : HELLO_SERVER);
            else
                hs_feed.push_back(8'($urandom_range(255)));
            hs_feed.push_back(($urandom_range(99) < 90) ? 8'h00 : 8'($urandom_range(255)));
            hs_feed.push_back(8'h00);
            hs_feed.push_back(8'(n));
            repeat (n)
                hs_feed.push_back(8'($urandom_range(255)));
        end
        return hs_feed.pop_front();
    endfunction

    // Appends one record to the pending bytes. Most records are well formed
    // with random content; the rest have a bad type, version or length, and
    // a few are plain line noise that throws the framer out of step.
    function automatic void queue_record();
        int unsigned r;
        int unsigned nj;
        logic [7:0]  typ;
        logic [7:0]  maj;
        logic [7:0]  mnr;
        logic [15:0] len;
        logic [15:0] limit_len;
        bit          ok;
        limit_len = sb.rec_len_limit;
        if ($urandom_range(99) < 5)
        begin
            nj = $urandom_range(1, 6);
            for (int i = 0; i < nj; i++)
                push_byte(8'($urandom_range(255)), i == nj - 1);
            return;
        end
        r = $urandom_range(99);
        if (r < 55)
            typ = TYPE_HANDSHAKE;
        else if (r < 65)
            typ = TYPE_CCS;
        else if (r < 75)
            typ = TYPE_ALERT;
        else if (r < 85)
            typ = TYPE_LAST;
        else
            typ = 8'($urandom_range(255));
        maj = ($urandom_range(99) < 95) ? MAJOR_VERSION : 8'($urandom_range(255));
        mnr = ($urandom_range(99) < 90) ? 8'($urandom_range(0, MINOR_MAX))
                                        : 8'($urandom_range(MINOR_MAX + 1, 255));
        r = $urandom_range(99);
        if (r < 78)
            len = 16'($urandom_range(1, 20));
        else if (r < 85)
            len = 16'd0;
        else if (r < 91)
            len = limit_len;
        else if (r < 96)
            len = (limit_len >= 16'd2 && limit_len <= 16'd41) ? limit_len - 16'd1
                                                              : 16'($urandom_range(1, 20));
        else
            len = 16'($urandom_range(65535)) | 16'h8000;
        ok = typ >= TYPE_CCS && typ <= TYPE_LAST && maj == MAJOR_VERSION &&
             mnr <= MINOR_MAX && len != 16'd0 && len < limit_len;
        // Long bodies are not worth the cycles; push such a length to the limit.
        if (ok && len > 16'd64)
        begin
            len = limit_len;
            ok = 1'b0;
        end
        queue_header(typ, maj, mnr, len);
        if (!ok)
        begin
            // The segment ends at once or after a little junk, so the next
            // record starts on a fresh segment.
            nj = $urandom_range(0, 2);
            for (int i = 0; i <= nj; i++)
                push_byte(8'($urandom_range(255)), i == nj);
            return;
        end
        for (int i = 0; i < len; i++)
            push_byte((typ == TYPE_HANDSHAKE) ? next_hs_byte() : 8'($urandom_range(255)),
                      (i == len - 1) ? ($urandom_range(99) < 50) : ($urandom_range(99) < 4));
    endfunction

    // Offers one word and holds it until the framer takes it. Idle cycles
    // before the word drop tvalid; back-to-back words keep it high.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Sends what is pending, then random records until at least count bytes
    // have gone out, finishing the record in progress.
    task automatic feed_bytes(input int unsigned count);
        int unsigned sent;
        logic [7:0]  b;
        logic        l;
        sent = 0;
        while (sent < count || pend_byte.size() != 0)
        begin
            if (pend_byte.size() == 0)
                queue_record();
            b = pend_byte.pop_front();
            l = pend_last.pop_front();
            send_byte(b, l);
            sent++;
        end
    endtask

    // Waits until every expected word has come back, so registers may change.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes one register; the scoreboard follows at the edge that writes it.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_idling(input int unsigned src, input int unsigned sink);
        src_idle_pct   = src;
        sink_stall_pct = sink;
    endtask

    initial
    begin
        sb = new();
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_FROM_CLIENT;
        cfg_data      <= 16'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed start under the reset settings. A header with a type just
        // below the valid range is rejected, and the rest of its segment is
        // skipped up to the end mark. Then a client hello message is split
        // over two handshake records; the second record's header is checked
        // while nothing has been counted yet, and its first body byte is the
        // server hello type, so the hello flag must rise there.
        set_idling(0, 0);
        queue_header(TYPE_CCS - 8'd1, MAJOR_VERSION, 8'h01, 16'd5);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b1);
        queue_header(TYPE_HANDSHAKE, MAJOR_VERSION, MINOR_MAX, 16'd5);
        push_byte(HELLO_CLIENT, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h08, 1'b0);
        push_byte(8'hAB, 1'b0);
        queue_header(TYPE_HANDSHAKE, MAJOR_VERSION, 8'h00, 16'd7);
        push_byte(HELLO_SERVER, 1'b0);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b0);
        push_byte(8'h33, 1'b0);
        push_byte(8'h44, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        feed_bytes(0);
        settle();

        // Server direction, widest length limit, sparse sender.
        write_reg(CFG_FROM_CLIENT, 16'd0);
        write_reg(CFG_REC_LEN_LIMIT, 16'hFFFF);
        write_reg(CFG_MAX_RECORDS, 16'hFFFF);
        cfg_we <= 1'b0;
        set_idling(86, 0);
        feed_bytes(250);
        settle();

        // A zero length limit rejects every header; slow receiver.
        write_reg(CFG_FROM_CLIENT, 16'd1);
        write_reg(CFG_REC_LEN_LIMIT, 16'd0);
        cfg_we <= 1'b0;
        set_idling(0, 86);
        feed_bytes(60);
        settle();

        // Small limit so that lengths at and just below it come up often.
        write_reg(CFG_REC_LEN_LIMIT, 16'd24);
        write_reg(CFG_FROM_CLIENT, 16'd0);
        cfg_we <= 1'b0;
        set_idling(28, 28);
        feed_bytes(250);
        settle();

        // The unused register index must change nothing.
        write_reg(CFG_UNUSED_INDEX, 16'($urandom_range(65535)));
        write_reg(CFG_REC_LEN_LIMIT, REC_LEN_LIMIT_RESET);
        write_reg(CFG_FROM_CLIENT, 16'd1);
        cfg_we <= 1'b0;
        set_idling(0, 0);
        feed_bytes(250);
        settle();

        // Allow only a few more records or messages; once the count gets
        // there the framer ignores everything until reset.
        write_reg(CFG_MAX_RECORDS, sb.rec_count + 16'd3);
        cfg_we <= 1'b0;
        set_idling(0, 86);
        feed_bytes(150);
        settle();

        write_reg(CFG_MAX_RECORDS, 16'd0);
        cfg_we <= 1'b0;
        set_idling(28, 28);
        feed_bytes(40);
        settle();
        repeat (8) @(posedge clk);

        $display("Sent %0d payload bytes over seven register settings and four idle patterns,",
                 sb.n_bytes);
        $display("%0d words back: %0d record headers, %0d handshake headers,",
                 sb.n_results, sb.n_headers, sb.n_hs_headers);
        $display("%0d rejected, %0d closed.", sb.n_rejected, sb.n_closed);
        if (sb.expected_q.size() != 0)
            $display("%0d expected words never arrived", sb.expected_q.size());
        if (sb.mismatches > 10)
            $display("%0d mismatches in total", sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("[tls_record_framer_unit] OK");
        else
            $display("[tls_record_framer_unit] ERROR");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/tlsrf_pkg.sv
hw/rtl/tls_record_framer_unit.sv
tb/tb_tls_record_framer_unit.sv
